// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ONT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ont check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define ONT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ont check failed");

`endif

// ===== rtl/core/ont_pkg.sv =====
// ----------------------------------------------------------------------------
// ont_pkg
// Widths, stage counts, direction codes and stage payload types of the
// nearest-neighbor-interchange edge test.
// ----------------------------------------------------------------------------
package ont_pkg;

  // Field widths.
  localparam int RATIO_FRAC_BITS = 24;
  localparam int SIZE_W  = 13;
  localparam int AVG_W   = 32;
  localparam int DIR_W   = 2;
  localparam int CHG_W   = 35;

  // Derived internal widths.
  localparam int PROD_W  = 2 * SIZE_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int SUM_W   = SIZE_W + 1;
  localparam int DEN_W   = 2 * SUM_W;
  localparam int ASUM_W  = AVG_W + 1;
  localparam int RATIO_W = RATIO_FRAC_BITS + 1;
  localparam int DIFF_W  = ASUM_W + 1;
  localparam int P_W     = RATIO_W + 1 + DIFF_W;
  localparam int W_W     = P_W + 1;

  // Pipeline depth.
  localparam int FRONT_STAGES = 2;
  localparam int DIV_STEPS    = RATIO_W;
  localparam int LEN_STAGES   = 5;
  localparam int NSTG         = FRONT_STAGES + DIV_STEPS + LEN_STAGES;
  localparam int LANES        = 3;

  // Swap direction codes.
  localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

  // Values that ride along the ratio pipeline.
  typedef struct packed {
    logic              leaf;
    logic [ASUM_W-1:0] s_lurd;
    logic [ASUM_W-1:0] s_ruld;
    logic [ASUM_W-1:0] s_dulr;
  } side_t;

  // Numerators and denominators of the three ratios.
  typedef struct packed {
    logic [NUM_W-1:0] num01;
    logic [NUM_W-1:0] num2;
    logic [DEN_W-1:0] den0;
    logic [DEN_W-1:0] den1;
    logic [DEN_W-1:0] den2;
    side_t            side;
  } frac_t;

  // Finished ratios.
  typedef struct packed {
    logic [RATIO_W-1:0] l0;
    logic [RATIO_W-1:0] l1;
    logic [RATIO_W-1:0] l2;
    side_t              side;
  } ratio_t;

endpackage

// ===== rtl/core/ont_front.sv =====
// ----------------------------------------------------------------------------
// ont_front
// First two stages: size products and sums, then ratio numerators and
// denominators.
// ----------------------------------------------------------------------------
module ont_front import ont_pkg::*; (
  input  logic                    clk_i,
  input  logic [FRONT_STAGES-1:0] en_i,
  input  logic                    edge_at_leaf_i,
  input  logic [SIZE_W-1:0]       size_above_i,
  input  logic [SIZE_W-1:0]       size_sibling_i,
  input  logic [SIZE_W-1:0]       size_left_i,
  input  logic [SIZE_W-1:0]       size_right_i,
  input  logic [AVG_W-1:0]        avg_left_right_i,
  input  logic [AVG_W-1:0]        avg_left_up_i,
  input  logic [AVG_W-1:0]        avg_left_down_i,
  input  logic [AVG_W-1:0]        avg_right_up_i,
  input  logic [AVG_W-1:0]        avg_right_down_i,
  input  logic [AVG_W-1:0]        avg_down_up_i,
  output frac_t                   frac_o
);

  logic [PROD_W-1:0] bc_q, ad_q, cd_q, ab_q;
  logic [SUM_W-1:0]  sab_q, scd_q, sac_q, sbd_q, sad_q, sbc_q;
  side_t             side_q;
  frac_t             frac_q;

  // Stage one: pairwise products, pairwise sums and average sums.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      bc_q  <= PROD_W'(size_sibling_i) * PROD_W'(size_left_i);
      ad_q  <= PROD_W'(size_above_i) * PROD_W'(size_right_i);
      cd_q  <= PROD_W'(size_left_i) * PROD_W'(size_right_i);
      ab_q  <= PROD_W'(size_above_i) * PROD_W'(size_sibling_i);
      sab_q <= SUM_W'(size_above_i) + SUM_W'(size_sibling_i);
      scd_q <= SUM_W'(size_left_i) + SUM_W'(size_right_i);
      sac_q <= SUM_W'(size_above_i) + SUM_W'(size_left_i);
      sbd_q <= SUM_W'(size_sibling_i) + SUM_W'(size_right_i);
      sad_q <= SUM_W'(size_above_i) + SUM_W'(size_right_i);
      sbc_q <= SUM_W'(size_sibling_i) + SUM_W'(size_left_i);
      side_q.leaf   <= edge_at_leaf_i;
      side_q.s_lurd <= ASUM_W'(avg_left_up_i) + ASUM_W'(avg_right_down_i);
      side_q.s_ruld <= ASUM_W'(avg_right_up_i) + ASUM_W'(avg_left_down_i);
      side_q.s_dulr <= ASUM_W'(avg_down_up_i) + ASUM_W'(avg_left_right_i);
    end
  end

  // Stage two: numerators and the three denominator products.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      frac_q.num01 <= NUM_W'(bc_q) + NUM_W'(ad_q);
      frac_q.num2  <= NUM_W'(cd_q) + NUM_W'(ab_q);
      frac_q.den0  <= DEN_W'(sab_q) * DEN_W'(scd_q);
      frac_q.den1  <= DEN_W'(sac_q) * DEN_W'(sbd_q);
      frac_q.den2  <= DEN_W'(sad_q) * DEN_W'(sbc_q);
      frac_q.side  <= side_q;
    end
  end

  assign frac_o = frac_q;

endmodule

// ===== rtl/core/ont_div.sv =====
// ----------------------------------------------------------------------------
// ont_div
// Pipelined restoring division: one quotient bit per stage for the three
// mixing ratios side by side.
// ----------------------------------------------------------------------------
module ont_div import ont_pkg::*; (
  input  logic                 clk_i,
  input  logic [DIV_STEPS-1:0] en_i,
  input  frac_t                frac_i,
  output ratio_t               ratio_o
);

  // Each numerator never exceeds its denominator, so the quotient fits in
  // RATIO_W bits and the division starts with the remainder at num / 2.
  logic [DEN_W-1:0]   r_q   [DIV_STEPS][LANES];
  logic [RATIO_W-1:0] q_q   [DIV_STEPS][LANES];
  logic [DEN_W-1:0]   den_q [DIV_STEPS][LANES];
  side_t              side_q[DIV_STEPS];

  logic [DEN_W-1:0]   r_d   [DIV_STEPS][LANES];
  logic [RATIO_W-1:0] q_d   [DIV_STEPS][LANES];
  logic [DEN_W-1:0]   den_d [DIV_STEPS][LANES];
  side_t              side_d[DIV_STEPS];
  logic [NUM_W-1:0]   num   [LANES];
  logic [DEN_W-1:0]   den   [LANES];
  logic [DEN_W-1:0]   r_in  [DIV_STEPS][LANES];
  logic [RATIO_W-1:0] q_in  [DIV_STEPS][LANES];
  logic               nbit  [DIV_STEPS][LANES];
  logic [DEN_W:0]     trial [DIV_STEPS][LANES];
  logic               ge    [DIV_STEPS][LANES];

  always_comb begin
    num[0] = frac_i.num01;
    num[1] = frac_i.num01;
    num[2] = frac_i.num2;
    den[0] = frac_i.den0;
    den[1] = frac_i.den1;
    den[2] = frac_i.den2;
  end

  // One compare and subtract per stage and lane.
  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          r_in[s][l]  = DEN_W'(num[l] >> 1);
          q_in[s][l]  = '0;
          nbit[s][l]  = num[l][0];
          den_d[s][l] = den[l];
        end else begin
          r_in[s][l]  = r_q[s-1][l];
          q_in[s][l]  = q_q[s-1][l];
          nbit[s][l]  = 1'b0;
          den_d[s][l] = den_q[s-1][l];
        end
        trial[s][l] = {r_in[s][l], nbit[s][l]};
        ge[s][l]    = trial[s][l] >= {1'b0, den_d[s][l]};
        r_d[s][l]   = ge[s][l] ? DEN_W'(trial[s][l] - {1'b0, den_d[s][l]})
                               : trial[s][l][DEN_W-1:0];
        q_d[s][l]   = {q_in[s][l][RATIO_W-2:0], ge[s][l]};
      end
      side_d[s] = (s == 0) ? frac_i.side : side_q[s-1];
    end
  end

  // Stage registers.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (en_i[s]) begin
        for (int l = 0; l < LANES; l++) begin
          r_q[s][l]   <= r_d[s][l];
          q_q[s][l]   <= q_d[s][l];
          den_q[s][l] <= den_d[s][l];
        end
        side_q[s] <= side_d[s];
      end
    end
  end

  // A zero denominator gives a zero ratio.
  assign ratio_o.l0 = (den_q[DIV_STEPS-1][0] == '0) ? '0 : q_q[DIV_STEPS-1][0];
  assign ratio_o.l1 = (den_q[DIV_STEPS-1][1] == '0) ? '0 : q_q[DIV_STEPS-1][1];
  assign ratio_o.l2 = (den_q[DIV_STEPS-1][2] == '0) ? '0 : q_q[DIV_STEPS-1][2];
  assign ratio_o.side = side_q[DIV_STEPS-1];

endmodule

// ===== rtl/core/ont_len.sv =====
// ----------------------------------------------------------------------------
// ont_len
// Tree lengths of the three topologies, selection of the best one, and the
// output register.
// ----------------------------------------------------------------------------
module ont_len import ont_pkg::*; (
  input  logic                  clk_i,
  input  logic [LEN_STAGES-1:0] en_i,
  input  ratio_t                ratio_i,
  output logic [DIR_W-1:0]      swap_direction_o,
  output logic signed [CHG_W-1:0] length_change_o
);

  logic [RATIO_W-1:0] lam [LANES];
  logic [ASUM_W-1:0]  xs  [LANES];
  logic [ASUM_W-1:0]  ys  [LANES];
  logic [ASUM_W-1:0]  zs  [LANES];
  logic [DIFF_W-1:0]  dxy [LANES];
  logic [P_W-1:0]     p_d [LANES];

  logic [P_W-1:0]     p_q    [LANES];
  logic [DIFF_W-1:0]  base_q [LANES];
  logic               leaf1_q, leaf2_q;
  logic [W_W-1:0]     w_q    [LANES];
  logic [DIR_W-1:0]   dir3_q, dir4_q, dir5_q;
  logic [W_W-1:0]     w0_q, best_q;
  logic [CHG_W-1:0]   mag_q, chg_q;
  logic [W_W-1:0]     diff;
  logic [DIR_W-1:0]   dir_d;
  logic [W_W-1:0]     best_d;

  // Length is lam*(X-Y) + one*(Y+Z), doubled.
  always_comb begin
    lam[0] = ratio_i.l0;
    lam[1] = ratio_i.l1;
    lam[2] = ratio_i.l2;
    xs[0] = ratio_i.side.s_lurd; ys[0] = ratio_i.side.s_ruld; zs[0] = ratio_i.side.s_dulr;
    xs[1] = ratio_i.side.s_dulr; ys[1] = ratio_i.side.s_ruld; zs[1] = ratio_i.side.s_lurd;
    xs[2] = ratio_i.side.s_lurd; ys[2] = ratio_i.side.s_dulr; zs[2] = ratio_i.side.s_ruld;
    for (int l = 0; l < LANES; l++) begin
      dxy[l] = {1'b0, xs[l]} - {1'b0, ys[l]};
      p_d[l] = P_W'($signed({{(P_W-RATIO_W){1'b0}}, lam[l]})
             * $signed({{(P_W-DIFF_W){dxy[l][DIFF_W-1]}}, dxy[l]}));
    end
  end

  // Stage one: signed product and base sum.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int l = 0; l < LANES; l++) begin
        p_q[l]    <= p_d[l];
        base_q[l] <= {1'b0, ys[l]} + {1'b0, zs[l]};
      end
      leaf1_q <= ratio_i.side.leaf;
    end
  end

  // Stage two: full lengths.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int l = 0; l < LANES; l++) begin
        w_q[l] <= {p_q[l][P_W-1], p_q[l]}
                + {{(W_W-DIFF_W-RATIO_FRAC_BITS){1'b0}}, base_q[l],
                   {RATIO_FRAC_BITS{1'b0}}};
      end
      leaf2_q <= leaf1_q;
    end
  end

  // Pick the best topology; a leaf edge and ties keep the current one, then prefer right.
  always_comb begin
    if (leaf2_q || ((w_q[0] <= w_q[1]) && (w_q[0] <= w_q[2]))) begin
      dir_d  = DIR_NONE;
      best_d = w_q[0];
    end else if ((w_q[0] <= w_q[1]) || (w_q[2] <= w_q[1])) begin
      dir_d  = DIR_RIGHT;
      best_d = w_q[2];
    end else begin
      dir_d  = DIR_LEFT;
      best_d = w_q[1];
    end
  end

  // Stage three: selection.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dir3_q <= dir_d;
      w0_q   <= w_q[0];
      best_q <= best_d;
    end
  end

  // Stage four: magnitude of the gain in Q16.16.
  assign diff = w0_q - best_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      dir4_q <= dir3_q;
      mag_q  <= CHG_W'(diff >> (RATIO_FRAC_BITS + 1));
    end
  end

  // Stage five: output register.
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      dir5_q <= dir4_q;
      chg_q  <= CHG_W'(0) - mag_q;
    end
  end

  assign swap_direction_o = dir5_q;
  assign length_change_o  = $signed(chg_q);

endmodule

// ===== rtl/core/ols_nni_edge_test_unit.sv =====
// ----------------------------------------------------------------------------
// ols_nni_edge_test_unit
// Tests one internal tree edge for a nearest-neighbor interchange under
// ordinary least squares and reports the best swap and its length change.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (valid_i / stall_o) takes one edge request per cycle
//   while stall_o is low: four subtree sizes, six Q16.16 averages and the
//   leaf flag. The output channel (valid_o / stall_i) returns swap_direction_o
//   and length_change_o. The pipeline holds 32 register stages: valid_o rises
//   when a result reaches the last stage, and the result is taken there when
//   stall_i is low. The stages are 2 front stages, 25 division stages (one
//   quotient bit each, the ratio divider sets the depth) and 5 length and
//   selection stages. Throughput is one request per cycle while the receiver
//   does not stall.
//   When the receiver stalls, the result holds in the output register and
//   earlier stages keep filling empty slots; stall_o rises only when every
//   stage holds a request.
//   Reset clears all valid bits; the pipeline is empty and accepts at once.
// ----------------------------------------------------------------------------
module ols_nni_edge_test_unit import ont_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic                    edge_at_leaf_i,
  input  logic [SIZE_W-1:0]       size_above_i,
  input  logic [SIZE_W-1:0]       size_sibling_i,
  input  logic [SIZE_W-1:0]       size_left_i,
  input  logic [SIZE_W-1:0]       size_right_i,
  input  logic [AVG_W-1:0]        avg_left_right_i,
  input  logic [AVG_W-1:0]        avg_left_up_i,
  input  logic [AVG_W-1:0]        avg_left_down_i,
  input  logic [AVG_W-1:0]        avg_right_up_i,
  input  logic [AVG_W-1:0]        avg_right_down_i,
  input  logic [AVG_W-1:0]        avg_down_up_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [DIR_W-1:0]        swap_direction_o,
  output logic signed [CHG_W-1:0] length_change_o
);

  logic [NSTG-1:0] v_q, v_d;
  logic [NSTG-1:0] en;
  frac_t           frac;
  ratio_t          ratio;

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // The first stage takes the input valid, later stages take their predecessor.
  always_comb begin
    v_d[0] = en[0] ? valid_i : v_q[0];
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign stall_o = !en[0];
  assign valid_o = v_q[NSTG-1];

  ont_front u_front (
    .clk_i            (clk_i),
    .en_i             (en[FRONT_STAGES-1:0]),
    .edge_at_leaf_i   (edge_at_leaf_i),
    .size_above_i     (size_above_i),
    .size_sibling_i   (size_sibling_i),
    .size_left_i      (size_left_i),
    .size_right_i     (size_right_i),
    .avg_left_right_i (avg_left_right_i),
    .avg_left_up_i    (avg_left_up_i),
    .avg_left_down_i  (avg_left_down_i),
    .avg_right_up_i   (avg_right_up_i),
    .avg_right_down_i (avg_right_down_i),
    .avg_down_up_i    (avg_down_up_i),
    .frac_o           (frac)
  );

  ont_div u_div (
    .clk_i   (clk_i),
    .en_i    (en[FRONT_STAGES+DIV_STEPS-1:FRONT_STAGES]),
    .frac_i  (frac),
    .ratio_o (ratio)
  );

  ont_len u_len (
    .clk_i            (clk_i),
    .en_i             (en[NSTG-1:FRONT_STAGES+DIV_STEPS]),
    .ratio_i          (ratio),
    .swap_direction_o (swap_direction_o),
    .length_change_o  (length_change_o)
  );

endmodule

// ===== rtl/core/ont_checker.sv =====
// ----------------------------------------------------------------------------
// ont_checker
// Port-level checks of the edge test unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ont_checker import ont_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    stall_o,
  input logic                    valid_o,
  input logic                    stall_i,
  input logic [DIR_W-1:0]        swap_direction_o,
  input logic signed [CHG_W-1:0] length_change_o
);

  // A stalled result stays valid and unchanged.
  `ONT_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o)
  `ONT_ASSERT_NEXT(a_out_stable, valid_o && stall_i, $stable(length_change_o))

  // No swap means no change in length.
  `ONT_ASSERT_NOW(a_none_zero, valid_o && (swap_direction_o == DIR_NONE),
                  length_change_o == '0)

  // A swap never lengthens the tree.
  `ONT_ASSERT_NOW(a_change_sign, valid_o && (swap_direction_o != DIR_NONE),
                  length_change_o[CHG_W-1] || (length_change_o == '0))

  // The pipeline only pushes back when the output is held.
  `ONT_ASSERT_NOW(a_stall_cause, stall_o, valid_o && stall_i)

endmodule

bind ols_nni_edge_test_unit ont_checker u_checker (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-neighbor-interchange edge test. Edge
// requests go in through bursts with random gaps while the result side stalls
// on a pattern of its own. A scoreboard predicts the swap direction and the
// length change of every accepted request and checks them in order.
// ----------------------------------------------------------------------------
module tb;
  import ont_pkg::*;

  typedef struct {
    logic              leaf;
    logic [SIZE_W-1:0] sa, sb, sl, sr;
    logic [AVG_W-1:0]  lr, lu, ld, ru, rd, du;
  } edge_req_t;

  typedef struct {
    logic [DIR_W-1:0]        dir;
    logic signed [CHG_W-1:0] chg;
  } swap_res_t;

  // Predicts each edge decision and checks results against them in order.
  class swap_scoreboard;
    swap_res_t pending_q[$];
    int        errors;
    int        checked;
    int        dir_seen[3];

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    // Ratio with RATIO_FRAC_BITS fraction bits; zero when the divisor is zero.
    function logic [63:0] mix_ratio(logic [63:0] num, logic [63:0] den);
      if (den == 0) return 64'd0;
      return (num << RATIO_FRAC_BITS) / den;
    endfunction

    // Twice the OLS length, held exactly.
    function logic [127:0] twice_length(logic [63:0] lam, logic [63:0] x,
                                        logic [63:0] y, logic [63:0] z);
      logic [127:0] one;
      one = 128'd1 << RATIO_FRAC_BITS;
      if (lam > one) lam = one[63:0];
      return 128'(lam) * 128'(x) + (one - 128'(lam)) * 128'(y) + 128'(z) * one;
    endfunction

    function void note_request(edge_req_t r);
      logic [63:0]  a, b, c, d, l0, l1, l2, s_lurd, s_ruld, s_dulr;
      logic [127:0] w0, w1, w2, best, mag;
      swap_res_t    res;
      res.dir = DIR_NONE;
      res.chg = '0;
      if (!r.leaf) begin
        a = r.sa; b = r.sb; c = r.sl; d = r.sr;
        l0 = mix_ratio(b * c + a * d, (a + b) * (c + d));
        l1 = mix_ratio(b * c + a * d, (a + c) * (b + d));
        l2 = mix_ratio(c * d + a * b, (a + d) * (b + c));
        s_lurd = 64'(r.lu) + 64'(r.rd);
        s_ruld = 64'(r.ru) + 64'(r.ld);
        s_dulr = 64'(r.du) + 64'(r.lr);
        w0 = twice_length(l0, s_lurd, s_ruld, s_dulr);
        w1 = twice_length(l1, s_dulr, s_ruld, s_lurd);
        w2 = twice_length(l2, s_lurd, s_dulr, s_ruld);
        best = w0;
        // Ties keep the current topology; the right swap wins a tie with the left.
        if (w0 <= w1 && w0 <= w2) begin
          res.dir = DIR_NONE;
        end else if (w2 <= w1) begin
          res.dir = DIR_RIGHT;
          best = w2;
        end else begin
          res.dir = DIR_LEFT;
          best = w1;
        end
        if (res.dir != DIR_NONE) begin
          mag = (w0 - best) >> (RATIO_FRAC_BITS + 1);
          res.chg = -CHG_W'(mag);
        end
      end
      pending_q.push_back(res);
    endfunction

    task check_result(logic [DIR_W-1:0] dir, logic signed [CHG_W-1:0] chg);
      swap_res_t exp_res;
      if (pending_q.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      exp_res = pending_q.pop_front();
      checked++;
      if (exp_res.dir <= DIR_RIGHT) dir_seen[exp_res.dir]++;
      if (dir !== exp_res.dir)
        report($sformatf("swap_direction %0d, expected %0d", dir, exp_res.dir));
      if (chg !== exp_res.chg)
        report($sformatf("length_change %0d, expected %0d", chg, exp_res.chg));
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    valid_i = 1'b0;
  logic                    stall_o;
  logic                    edge_at_leaf_i = 1'b0;
  logic [SIZE_W-1:0]       size_above_i = '0, size_sibling_i = '0;
  logic [SIZE_W-1:0]       size_left_i = '0, size_right_i = '0;
  logic [AVG_W-1:0]        avg_left_right_i = '0, avg_left_up_i = '0;
  logic [AVG_W-1:0]        avg_left_down_i = '0, avg_right_up_i = '0;
  logic [AVG_W-1:0]        avg_right_down_i = '0, avg_down_up_i = '0;
  logic                    valid_o;
  logic                    stall_i = 1'b0;
  logic [DIR_W-1:0]        swap_direction_o;
  logic signed [CHG_W-1:0] length_change_o;

  swap_scoreboard sb = new();
  int             sent;

  always #5 clk_i = ~clk_i;

  ols_nni_edge_test_unit u_top (.*);

  // Watch both handshakes at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && valid_i && !stall_o)
      sb.note_request('{edge_at_leaf_i, size_above_i, size_sibling_i, size_left_i,
                        size_right_i, avg_left_right_i, avg_left_up_i,
                        avg_left_down_i, avg_right_up_i, avg_right_down_i,
                        avg_down_up_i});
    if (rst_ni && valid_o && !stall_i)
      sb.check_result(swap_direction_o, length_change_o);
  end

  // The receiver switches between no stall, light stall and heavy stall.
  int stall_mode = 0;
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: stall_i <= 1'b0;
      1: stall_i <= ($urandom_range(0, 99) < 30);
      default: stall_i <= ($urandom_range(0, 99) < 80);
    endcase
  end

  // Drives one request and holds it until it is accepted.
  task send_request(edge_req_t r);
    @(negedge clk_i);
    valid_i = 1'b1;
    edge_at_leaf_i = r.leaf;
    size_above_i = r.sa; size_sibling_i = r.sb;
    size_left_i = r.sl; size_right_i = r.sr;
    avg_left_right_i = r.lr; avg_left_up_i = r.lu; avg_left_down_i = r.ld;
    avg_right_up_i = r.ru; avg_right_down_i = r.rd; avg_down_up_i = r.du;
    do @(posedge clk_i); while (stall_o);
    sent++;
  endtask

  task idle_cycles(int n);
    @(negedge clk_i);
    valid_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return SIZE_W'($urandom_range(1, 16));
    if (k < 90) return SIZE_W'($urandom_range(1, 4096));
    return SIZE_W'($urandom_range(0, 8191));
  endfunction

  function automatic logic [AVG_W-1:0] rand_avg(logic [AVG_W-1:0] base);
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return base + AVG_W'($urandom_range(0, 32'h0004_0000));
    if (k < 95) return $urandom();
    return $urandom_range(0, 1) ? '1 : '0;
  endfunction

  function automatic edge_req_t rand_request();
    edge_req_t    r;
    logic [AVG_W-1:0] base;
    base = $urandom() >> $urandom_range(0, 16);
    r.leaf = ($urandom_range(0, 99) < 8);
    r.sa = rand_size(); r.sb = rand_size(); r.sl = rand_size(); r.sr = rand_size();
    r.lr = rand_avg(base); r.lu = rand_avg(base); r.ld = rand_avg(base);
    r.ru = rand_avg(base); r.rd = rand_avg(base); r.du = rand_avg(base);
    return r;
  endfunction

  initial begin
    edge_req_t directed_q[$];
    int        burst;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: leaf edge, size extremes, zero sizes, averages at the
    // extremes, equal averages, and cases that favor each swap.
    directed_q.push_back('{1'b1, 13'd5, 13'd6, 13'd7, 13'd8, '1, '1, '1, '1, '1, '1});
    directed_q.push_back('{1'b0, 13'd1, 13'd1, 13'd1, 13'd1, '0, '0, '0, '0, '0, '0});
    directed_q.push_back('{1'b0, 13'd1, 13'd1, 13'd1, 13'd1, '1, '1, '1, '1, '1, '1});
    directed_q.push_back('{1'b0, '1, '1, '1, '1, '1, '0, '1, '0, '1, '0});
    directed_q.push_back('{1'b0, '1, '1, '1, '1, '0, '1, '0, '1, '0, '1});
    directed_q.push_back('{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 32'd1, 32'd2, 32'd3,
                           32'd4, 32'd5, 32'd6});
    directed_q.push_back('{1'b0, 13'd0, 13'd3, 13'd0, 13'd9, '1, 32'd7, '0, 32'd9,
                           '1, 32'd0});
    directed_q.push_back('{1'b0, 13'd4096, 13'd1, 13'd1, 13'd4096, 32'h0001_0000,
                           32'h0008_0000, 32'h0002_0000, 32'h0003_0000,
                           32'h0007_0000, 32'h0009_0000});
    // Left swap favored: small left-up and right-down sums dominate.
    directed_q.push_back('{1'b0, 13'd3, 13'd4, 13'd5, 13'd6, 32'h0050_0000,
                           32'h0001_0000, 32'h0040_0000, 32'h0030_0000,
                           32'h0001_0000, 32'h0050_0000});
    // Left swap favored again.
    directed_q.push_back('{1'b0, 13'd3, 13'd4, 13'd5, 13'd6, 32'h0050_0000,
                           32'h0001_0000, 32'h0001_0000, 32'h0040_0000,
                           32'h0001_0000, 32'h0050_0000});
    directed_q.push_back('{1'b0, 13'd8191, 13'd1, 13'd8191, 13'd1, 32'hAAAA_AAAA,
                           32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                           32'hAAAA_AAAA, 32'h5555_5555});
    directed_q.push_back('{1'b0, 13'h1555, 13'h0AAA, 13'h1555, 13'h0AAA, 32'h5555_5555,
                           32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                           32'h5555_5555, 32'hAAAA_AAAA});
    foreach (directed_q[i]) send_request(directed_q[i]);

    // Random part in bursts, with a stretch of back-to-back requests.
    while (sent < 1350) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_request(rand_request());
      if (sent < 200 || sent > 900 || $urandom_range(0, 3) == 0)
        idle_cycles($urandom_range(0, 12));
    end
    idle_cycles(0);

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Checked %0d edge results from %0d requests.", sb.checked, sent);
    $display("Outcomes: %0d kept, %0d left swaps, %0d right swaps.",
             sb.dir_seen[DIR_NONE], sb.dir_seen[DIR_LEFT], sb.dir_seen[DIR_RIGHT]);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding.", sb.pending_q.size());
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== ols_nni_edge_test_unit.f =====
+incdir+rtl/core
rtl/core/ont_pkg.sv
rtl/core/ont_front.sv
rtl/core/ont_div.sv
rtl/core/ont_len.sv
rtl/core/ols_nni_edge_test_unit.sv
rtl/core/ont_checker.sv
tb/sv/tb.sv
